>>> hdl/fadd_pkg.sv
// Package for the float adder with integer conversion.
// Shared types, constants and a helper function; no dependencies.
package fadd_pkg;

	localparam int WordW = 32;
	localparam int MantW = 27;   // signed aligned mantissa
	localparam int SumW  = 28;   // sum of two aligned mantissas
	localparam int ExpW  = 8;

	localparam logic [31:0] SignBit    = 32'h8000_0000;
	localparam logic [22:0] FracMask   = 23'h7F_FFFF;
	localparam logic [7:0]  IntExp     = 8'd150;
	localparam logic [4:0]  MaxShift   = 5'd31;
	localparam logic [23:0] IntMask    = 24'hFF_FFFF;

	// Classified item handed from front to back
	typedef struct packed {
		logic signed [MantW-1:0] xa;
		logic signed [MantW-1:0] ya;
		logic [ExpW-1:0]         e0;
		logic                    floor_mode;
		logic                    x_zero;
		logic                    y_zero;
		logic                    is_int;
		logic [WordW-1:0]        x_word;
		logic [WordW-1:0]        y_word;
	} fadd_item_t;

	// Arithmetic right shift that saturates at 31 places
	function automatic logic signed [MantW-1:0] asr_sat(
		input logic signed [MantW-1:0] v, input logic [7:0] s);
		logic [4:0] sh;
		begin
			sh = (s > 8'(MaxShift)) ? MaxShift : s[4:0];
			asr_sat = v >>> sh;
		end
	endfunction

endpackage

>>> hdl/fadd_front.sv
// Front end: accepts a transaction, unpacks and aligns the operands.
// Depends on fadd_pkg.
module fadd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          x_operand,
	input  logic [31:0]          y_operand,
	input  logic [1:0]           req_type,
	output logic                 item_valid,
	input  logic                 item_ready,
	output fadd_pkg::fadd_item_t item
);
	logic                              is_int, floor_mode;
	logic [7:0]                        xe, ye;
	logic signed [fadd_pkg::MantW-1:0] xm, ym, xmag, ymag;
	logic [23:0]                       iv;
	fadd_pkg::fadd_item_t              nxt;
	fadd_pkg::fadd_item_t              item_s1;
	logic                              valid_s1;

	// Unpack operands into signed mantissas
	always_comb begin
		is_int     = req_type[0];
		floor_mode = req_type[1];
		iv         = x_operand[23:0] & fadd_pkg::IntMask;
		xmag = fadd_pkg::MantW'({x_operand[22:0], 1'b0}) | (27'sd1 <<< 24);
		if (is_int) begin
			xe = fadd_pkg::IntExp;
			xm = {{2{iv[23]}}, iv, 1'b0};
		end else begin
			xe = x_operand[30:23];
			xm = x_operand[31] ? -xmag : xmag;
		end
		ye   = y_operand[30:23];
		ymag = fadd_pkg::MantW'({y_operand[22:0], 1'b0});
		if (!is_int && !floor_mode) ymag = ymag | (27'sd1 <<< 24);
		ym = y_operand[31] ? -ymag : ymag;
	end

	// Align to the larger exponent
	always_comb begin
		nxt = '0;
		nxt.xa = xm;
		nxt.ya = ym;
		if (ye > xe) begin
			nxt.e0 = ye;
			nxt.xa = fadd_pkg::asr_sat(xm, ye - xe);
		end else begin
			nxt.e0 = xe;
			nxt.ya = fadd_pkg::asr_sat(ym, xe - ye);
		end
		nxt.floor_mode = floor_mode;
		nxt.is_int     = is_int;
		nxt.x_zero     = (x_operand[30:0] == '0);
		nxt.y_zero     = (y_operand[30:0] == '0);
		nxt.x_word     = x_operand;
		nxt.y_word     = y_operand;
	end

	assign in_ready = !valid_s1 || item_ready;

	// Stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= nxt;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

>>> hdl/fadd_queue.sv
// Two-entry queue between front and back ends.
// Depends on fadd_pkg.
module fadd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	output logic                 wr_ready,
	input  fadd_pkg::fadd_item_t wr_item,
	output logic                 rd_valid,
	input  logic                 rd_ready,
	output fadd_pkg::fadd_item_t rd_item
);
	fadd_pkg::fadd_item_t mem_q [2];
	logic                 wptr_q, rptr_q;
	logic [1:0]           count_q;
	logic                 push, pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_item  = mem_q[rptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

	// Queue never exceeds two entries
	assert property (@(posedge clk) disable iff (!arst_n) count_q != 2'd3)
		else $error("queue count out of range");
	// Full queue refuses writes
	assert property (@(posedge clk) disable iff (!arst_n) count_q == 2'd2 |-> !wr_ready)
		else $error("full queue ready");
	// Empty queue holds no valid output
	assert property (@(posedge clk) disable iff (!arst_n) count_q == 2'd0 |-> !rd_valid)
		else $error("empty queue valid");

endmodule

>>> hdl/fadd_back.sv
// Back end: adds, rounds, normalises and packs the result.
// Depends on fadd_pkg.
module fadd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  fadd_pkg::fadd_item_t item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          result_word
);
	logic signed [fadd_pkg::SumW-1:0] sum;
	logic [fadd_pkg::SumW-1:0]        mag;
	logic [26:0]                      t3;
	logic [4:0]                       lz;
	logic signed [10:0]               e1;
	logic [31:0]                      fl, packed_w, r;
	logic                             found;
	logic                             valid_s2;
	logic [31:0]                      result_s2;

	// Sum, rounding and leading-zero normalisation
	always_comb begin
		sum   = fadd_pkg::SumW'(item.xa) + fadd_pkg::SumW'(item.ya);
		mag   = (sum < 0 ? -sum : sum) + 28'd1;
		e1    = 11'(item.e0) + 11'sd1;
		t3    = mag[27:1];
		lz    = 5'd0;
		found = 1'b0;
		if ((mag & 28'h3ff_fffc) != '0) begin
			for (int i = 0; i < 25; i++) begin
				if (!found && t3[24 - i]) begin
					found = 1'b1;
					lz    = 5'(i);
				end
			end
			if (!found) lz = 5'd25;
			t3 = t3 << lz;
			e1 = e1 - 11'(lz);
		end else begin
			t3 = t3 << 24;
			e1 = e1 - 11'sd24;
		end
		// only bits that land in the 32-bit word matter
		fl = 32'(sum >>> 1);
		packed_w = (sum < 0 ? fadd_pkg::SignBit : 32'd0)
			| (32'(e1[8:0]) << 23)
			| (32'(t3[23:1]) & 32'(fadd_pkg::FracMask));
		if (item.floor_mode) r = fl;
		else if (item.x_zero) r = item.is_int ? 32'd0 : item.y_word;
		else if (item.y_zero) r = item.x_word;
		else if ((t3[24:0] == '0) || e1 < 0) r = 32'd0;
		else r = packed_w;
	end

	assign item_ready = !valid_s2 || out_ready;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (item_ready) begin
			valid_s2 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			result_s2 <= r;
		end
	end

	assign out_valid   = valid_s2;
	assign result_word = result_s2;

endmodule

>>> hdl/float_add_with_int_convert_top.sv
// Float adder with integer conversion modes.
// Channels: in (x_operand, y_operand, req_type) and out (result_word), each
// with valid and ready; a transaction moves when both are high.
// req_type bit 0 reads x as a 24-bit signed integer (int to float); bit 1
// returns the aligned sum halved as an integer (floor conversion);
// otherwise a plain single-precision add without NaN or infinity handling.
// Structure: a front end aligns operands into a register, a two-entry queue
// decouples it from the back end, which adds, normalises and registers.
// With no stall, an input transaction passes the front register, the queue
// and the back output register in that order before its result is valid.
// Throughput: one transaction per cycle while out_ready stays high; the front
// register and the back output register each hold one item, so the rate is set by them.
// Reset clears all valid flags; no result is pending afterwards.
// When the receiver stalls, the output register holds, the queue fills, and
// in_ready falls once the front register and the queue are all occupied.
// Depends on fadd_pkg, fadd_front, fadd_queue and fadd_back.
module float_add_with_int_convert_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] x_operand,
	input  logic [31:0] y_operand,
	input  logic [1:0]  req_type,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_word
);
	logic                 f_valid, f_ready, b_valid, b_ready;
	fadd_pkg::fadd_item_t f_item, b_item;

	fadd_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .x_operand, .y_operand, .req_type,
		.item_valid(f_valid), .item_ready(f_ready), .item(f_item)
	);

	fadd_queue u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
	);

	fadd_back u_back (
		.clk, .arst_n, .item_valid(b_valid), .item_ready(b_ready), .item(b_item),
		.out_valid, .out_ready, .result_word
	);

endmodule
